### hw/rtl/fwpd_pkg.sv
package fwpd_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_HEAD,
        S_SH_RD,
        S_SH_WR,
        S_INS_RD,
        S_INS_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_EMIT
    } state_t;

endpackage

### hw/rtl/fifo_with_positional_delete_top.sv
// Bounded queue of signed 32-bit words with pop, push, positional delete,
// grouped front insert and dump.
// The command channel (s_*) takes one transaction while s_ready is high; the
// block then works on it alone and drops s_ready until its last result has
// been handed to the result register. The result channel (m_*) gives one
// transaction per command, or one per stored word for a dump, with m_last
// set on the final one.
// Each moved word takes a read state and then a write state in the walk over
// the word store. Push and unknown commands go straight to the result; pop
// reads the head and then shifts every later word down, delete shifts the
// words above the position down, front insert shifts the words from the
// offset up and then writes the new word, and a dump reads and hands out each
// word in turn. s_ready rises again in the cycle after the last result is loaded.
// A stalled receiver holds the result register; the block keeps working
// until it has a further result to load and then waits.
// Reset clears the count, the insert offset and the handshakes; the store
// itself is not cleared, since only entries below the count are ever read.
module fifo_with_positional_delete_top
    import fwpd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic [POS_W-1:0]         s_position,
    input  logic                     s_first_in_group,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_data_out,
    output logic [STAT_W-1:0]        m_status,
    output logic [OCC_W-1:0]         m_occupancy,
    output logic                     m_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] goff_reg, goff_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] at_reg, at_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [DATA_W-1:0] value_reg, value_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic first_reg, first_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;

    logic m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [OCC_W-1:0] m_occ_reg, m_occ_next;
    logic m_last_reg, m_last_next;

    logic rd_en, wr_en;
    logic [AW-1:0] raddr, waddr;
    logic [DATA_W-1:0] wdata;

    logic out_free;
    logic [CW-1:0] idx_inc, idx_dec, offset;

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_data_out  = m_data_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occ_reg;
    assign m_last      = m_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign offset   = first_reg ? '0 : goff_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            goff_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            goff_reg    <= goff_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg        <= idx_next;
        at_reg         <= at_next;
        cmd_reg        <= cmd_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        first_reg      <= first_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
        m_occ_reg      <= m_occ_next;
        m_last_reg     <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        goff_next       = goff_reg;
        idx_next        = idx_reg;
        at_next         = at_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        first_next      = first_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        m_occ_next      = m_occ_reg;
        m_last_next     = m_last_reg;
        rd_en           = 1'b0;
        raddr           = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        waddr           = idx_reg[AW-1:0];
        wdata           = rdata_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    value_next = s_value;
                    pos_next   = s_position;
                    first_next = s_first_in_group;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_data_next   = '0;
                res_status_next = ST_OK;
                state_next      = S_EMIT;
                case (cmd_reg)
                    CMD_PUSH: begin
                        if (count_reg == FULL_COUNT) begin
                            res_status_next = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            waddr      = count_reg[AW-1:0];
                            wdata      = value_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_POP: begin
                        if (count_reg == '0) begin
                            res_data_next   = '1;
                            res_status_next = ST_EMPTY;
                        end else begin
                            rd_en      = 1'b1;
                            raddr      = '0;
                            idx_next   = '0;
                            state_next = S_POP_HEAD;
                        end
                    end
                    CMD_DELETE: begin
                        if (pos_reg == '0 || pos_reg >= POS_W'(count_reg)) begin
                            res_status_next = ST_BADPOS;
                        end else begin
                            idx_next   = CW'(pos_reg);
                            state_next = S_SH_RD;
                        end
                    end
                    CMD_INSERT: begin
                        // The offset restarts on a group's first word even if
                        // the word itself is then dropped.
                        goff_next = offset;
                        if (count_reg == FULL_COUNT) begin
                            res_status_next = ST_FULL;
                        end else begin
                            at_next    = (offset > count_reg) ? count_reg : offset;
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    CMD_DUMP: begin
                        if (count_reg == '0) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            idx_next   = '0;
                            state_next = S_DUMP_RD;
                        end
                    end
                    default: begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_POP_HEAD: begin
                res_data_next = rdata_reg;
                state_next    = S_SH_RD;
            end
            S_SH_RD: begin
                if (idx_inc < count_reg) begin
                    rd_en      = 1'b1;
                    raddr      = idx_inc[AW-1:0];
                    state_next = S_SH_WR;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = S_EMIT;
                end
            end
            S_SH_WR: begin
                wr_en      = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata_reg;
                idx_next   = idx_inc;
                state_next = S_SH_RD;
            end
            S_INS_RD: begin
                if (idx_reg > at_reg) begin
                    rd_en      = 1'b1;
                    raddr      = idx_dec[AW-1:0];
                    state_next = S_INS_WR;
                end else begin
                    wr_en      = 1'b1;
                    waddr      = at_reg[AW-1:0];
                    wdata      = value_reg;
                    count_next = count_reg + CW'(1);
                    goff_next  = at_reg + CW'(1);
                    state_next = S_EMIT;
                end
            end
            S_INS_WR: begin
                wr_en      = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata_reg;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end
            S_DUMP_RD: begin
                rd_en      = 1'b1;
                raddr      = idx_reg[AW-1:0];
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                // The read data register holds its word until the result
                // register has room for it.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = rdata_reg;
                    m_status_next = ST_OK;
                    m_occ_next    = OCC_W'(count_reg);
                    m_last_next   = (idx_inc == count_reg);
                    if (idx_inc == count_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = S_DUMP_RD;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res_data_reg;
                    m_status_next = res_status_reg;
                    m_occ_next    = OCC_W'(count_reg);
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sim/fifo_with_positional_delete_top_tb.sv
`timescale 1ns / 1ps

module fifo_with_positional_delete_top_tb;
    import fwpd_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 42;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic                     first_in_group;
    } queue_cmd_t;

    typedef struct {
        logic signed [DATA_W-1:0] data_out;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } queue_result_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd;
    logic signed [DATA_W-1:0] s_value;
    logic [POS_W-1:0]         s_position;
    logic                     s_first_in_group;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_data_out;
    logic [STAT_W-1:0]        m_status;
    logic [OCC_W-1:0]         m_occupancy;
    logic                     m_last;

    queue_cmd_t    pending_cmds[$];
    queue_result_t expected_results[$];
    queue_cmd_t    next_cmd;

    // Predicted contents of the word store.
    logic signed [DATA_W-1:0] model_words[DEPTH];
    int model_count;
    int model_offset;

    // Rough occupancy tracked while generating, so sequences can aim at full and empty.
    int gen_count;
    int gen_issued;

    int  error_count;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  cmd_fire;

    fifo_with_positional_delete_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .s_position      (s_position),
        .s_first_in_group(s_first_in_group),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .m_status        (m_status),
        .m_occupancy     (m_occupancy),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void expect_result(input logic signed [DATA_W-1:0] data,
                                          input logic [STAT_W-1:0] status, input logic last);
        queue_result_t r;
        r.data_out  = data;
        r.status    = status;
        r.occupancy = OCC_W'(model_count);
        r.last      = last;
        expected_results.push_back(r);
    endfunction

    task automatic predict_queue(input queue_cmd_t c);
        int i;
        int at;
        logic signed [DATA_W-1:0] head;
        case (c.cmd)
            CMD_PUSH: begin
                if (model_count >= DEPTH) begin
                    expect_result('0, ST_FULL, 1'b1);
                end else begin
                    model_words[model_count] = c.value;
                    model_count++;
                    expect_result('0, ST_OK, 1'b1);
                end
            end
            CMD_POP: begin
                if (model_count == 0) begin
                    expect_result(-1, ST_EMPTY, 1'b1);
                end else begin
                    head = model_words[0];
                    for (i = 0; i + 1 < model_count; i++) model_words[i] = model_words[i + 1];
                    model_count--;
                    expect_result(head, ST_OK, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (int'(c.position) < 1 || int'(c.position) >= model_count) begin
                    expect_result('0, ST_BADPOS, 1'b1);
                end else begin
                    for (i = int'(c.position); i + 1 < model_count; i++)
                        model_words[i] = model_words[i + 1];
                    model_count--;
                    expect_result('0, ST_OK, 1'b1);
                end
            end
            CMD_INSERT: begin
                if (c.first_in_group) model_offset = 0;
                if (model_count >= DEPTH) begin
                    expect_result('0, ST_FULL, 1'b1);
                end else begin
                    // The offset can run past the end once words were removed mid-group.
                    at = (model_offset > model_count) ? model_count : model_offset;
                    for (i = model_count; i > at; i--) model_words[i] = model_words[i - 1];
                    model_words[at] = c.value;
                    model_count++;
                    model_offset = at + 1;
                    expect_result('0, ST_OK, 1'b1);
                end
            end
            CMD_DUMP: begin
                if (model_count == 0) begin
                    expect_result('0, ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < model_count; i++)
                        expect_result(model_words[i], ST_OK, i + 1 == model_count);
                end
            end
            default: expect_result('0, ST_OK, 1'b1);
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] value,
                             input int position, input logic first);
        queue_cmd_t c;
        c.cmd            = cmd;
        c.value          = value;
        c.position       = POS_W'(position);
        c.first_in_group = first;
        pending_cmds.push_back(c);
        gen_issued++;
        case (cmd)
            CMD_PUSH, CMD_INSERT: if (gen_count < DEPTH) gen_count++;
            CMD_POP:              if (gen_count > 0) gen_count--;
            CMD_DELETE:           if (position >= 1 && position < gen_count) gen_count--;
            default: ;
        endcase
    endtask

    task automatic fill_to_full();
        bit grouped;
        grouped = 1'b0;
        while (gen_count < DEPTH) begin
            if ($urandom_range(1)) begin
                queue_cmd(CMD_INSERT, rand_word(), $urandom_range(64), !grouped);
                grouped = 1'b1;
            end else begin
                queue_cmd(CMD_PUSH, rand_word(), $urandom_range(64), 1'($urandom_range(1)));
            end
        end
        repeat ($urandom_range(2, 1))
            queue_cmd($urandom_range(1) ? CMD_PUSH : CMD_INSERT, rand_word(),
                      $urandom_range(64), 1'($urandom_range(1)));
    endtask

    task automatic random_sequences(input int n);
        int stop_at;
        int len;
        int pos;
        stop_at = gen_issued + n;
        fill_to_full();
        while (gen_issued < stop_at) begin
            case ($urandom_range(9))
                0, 1: fill_to_full();
                2, 3: begin
                    len = $urandom_range(5, 1);
                    for (int k = 0; k < len; k++) begin
                        queue_cmd(CMD_INSERT, rand_word(), $urandom_range(64), k == 0);
                        // Removing words mid-group pushes the offset past the end.
                        if ($urandom_range(3) == 0)
                            queue_cmd($urandom_range(1) ? CMD_POP : CMD_DELETE, rand_word(),
                                      $urandom_range(2, 1), 1'b0);
                    end
                end
                4: begin
                    while (gen_count > 0) queue_cmd(CMD_POP, rand_word(), $urandom_range(64),
                                                    1'($urandom_range(1)));
                    queue_cmd(CMD_POP, rand_word(), $urandom_range(64), 1'($urandom_range(1)));
                end
                5, 6: begin
                    repeat ($urandom_range(3, 1)) begin
                        case ($urandom_range(5))
                            0:       pos = 0;
                            1:       pos = gen_count;
                            2:       pos = 64;
                            3:       pos = $urandom_range(64);
                            default: pos = (gen_count >= 2) ? $urandom_range(gen_count - 1, 1) : 1;
                        endcase
                        queue_cmd(CMD_DELETE, rand_word(), pos, 1'($urandom_range(1)));
                    end
                end
                7: queue_cmd(CMD_DUMP, rand_word(), $urandom_range(64), 1'($urandom_range(1)));
                8: repeat ($urandom_range(4, 1))
                    queue_cmd(CMD_PUSH, rand_word(), $urandom_range(64), 1'($urandom_range(1)));
                default: queue_cmd(CMD_W'($urandom_range(7)), rand_word(), $urandom_range(64),
                                   1'($urandom_range(1)));
            endcase
        end
        queue_cmd(CMD_DUMP, rand_word(), $urandom_range(64), 1'($urandom_range(1)));
    endtask

    task automatic wait_until_drained();
        do @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // Driver: a transaction, once offered, is held until it has been taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (s_valid && !cmd_fire) begin
                s_valid <= 1'b1;
            end else if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_cmd = pending_cmds.pop_front();
                s_valid          <= 1'b1;
                s_cmd            <= next_cmd.cmd;
                s_value          <= next_cmd.value;
                s_position       <= next_cmd.position;
                s_first_in_group <= next_cmd.first_in_group;
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predicts on every command taken and checks every result transaction.
    always @(posedge aclk) begin
        queue_result_t exp_r;
        cmd_fire = aresetn && s_valid && s_ready;
        if (cmd_fire) begin
            next_cmd.cmd            = s_cmd;
            next_cmd.value          = s_value;
            next_cmd.position       = s_position;
            next_cmd.first_in_group = s_first_in_group;
            predict_queue(next_cmd);
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with none expected: data %0d status %0d",
                                          m_data_out, m_status));
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data_out !== exp_r.data_out)
                    report_mismatch($sformatf("data_out got %0d, expected %0d",
                                              m_data_out, exp_r.data_out));
                if (m_status !== exp_r.status)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              m_status, exp_r.status));
                if (m_occupancy !== exp_r.occupancy)
                    report_mismatch($sformatf("occupancy got %0d, expected %0d",
                                              m_occupancy, exp_r.occupancy));
                if (m_last !== exp_r.last)
                    report_mismatch($sformatf("last got %0b, expected %0b",
                                              m_last, exp_r.last));
            end
        end
        if (cmd_fire || (aresetn && m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_cmd            = '0;
        s_value          = '0;
        s_position       = '0;
        s_first_in_group = 1'b0;
        m_ready          = 1'b0;
        cmd_fire         = 1'b0;
        error_count      = 0;
        idle_cycles      = 0;
        model_count      = 0;
        model_offset     = 0;
        gen_count        = 0;
        gen_issued       = 0;
        send_idle_pct    = 24;
        recv_idle_pct    = 71;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty store, unknown commands, extreme words and the bad positions.
        queue_cmd(CMD_POP, 0, 0, 1'b0);
        queue_cmd(CMD_DUMP, 0, 0, 1'b0);
        queue_cmd(CMD_DELETE, 0, 1, 1'b0);
        queue_cmd(3'd5, rand_word(), 64, 1'b1);
        queue_cmd(3'd6, rand_word(), $urandom_range(64), 1'b0);
        queue_cmd(3'd7, rand_word(), $urandom_range(64), 1'b1);
        queue_cmd(CMD_PUSH, 32'sh8000_0000, 0, 1'b0);
        queue_cmd(CMD_PUSH, 32'sh7fff_ffff, 64, 1'b1);
        queue_cmd(CMD_PUSH, -1, 0, 1'b0);
        queue_cmd(CMD_PUSH, 0, 0, 1'b0);
        queue_cmd(CMD_DELETE, 0, 0, 1'b0);
        queue_cmd(CMD_DELETE, 0, 4, 1'b0);
        queue_cmd(CMD_DELETE, 0, 64, 1'b0);
        queue_cmd(CMD_DELETE, 0, 3, 1'b0);
        queue_cmd(CMD_DELETE, 0, 1, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh11, 0, 1'b1);
        queue_cmd(CMD_INSERT, 32'sh22, 0, 1'b0);
        queue_cmd(CMD_INSERT, 32'sh33, 0, 1'b0);
        queue_cmd(CMD_POP, 0, 0, 1'b0);
        queue_cmd(CMD_POP, 0, 0, 1'b0);
        queue_cmd(CMD_DELETE, 0, 1, 1'b0);
        // The group offset now lies beyond the count, so this word goes to the back.
        queue_cmd(CMD_INSERT, 32'sh44, 0, 1'b0);
        queue_cmd(CMD_DUMP, 0, 0, 1'b0);
        queue_cmd(CMD_POP, 0, 0, 1'b0);
        queue_cmd(CMD_POP, 0, 0, 1'b0);
        queue_cmd(CMD_POP, 0, 0, 1'b0);
        random_sequences(PHASE_ITEMS);
        wait_until_drained();

        send_idle_pct = 71;
        recv_idle_pct = 24;
        random_sequences(PHASE_ITEMS);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_sequences(PHASE_ITEMS);
        wait_until_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
